/* rtl/core/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int ROW_BITS = 8;
    localparam int ROW_SH   = 3;

    localparam int SIZE_W   = 15;
    localparam int ALIGN_W  = 4;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic                load;
        logic                scan_init;
        logic                scan;
        logic                rng_scan;
        logic                rng_free;
        logic                mark_rd;
        logic                mark_wr;
        logic                st_we;
        logic [STATUS_W-1:0] st_val;
        logic                out_load;
    } bba_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic alloc_bad;
        logic free_outside;
        logic free_empty;
        logic scan_hit;
        logic scan_end;
        logic mark_last;
    } bba_sts_t;

endpackage

/* rtl/core/bba_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-clock RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/bba_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Request registers, block map RAM with per-row valid bits, first-fit scan,
// read-modify-write of map rows and result registers.
// ----------------------------------------------------------------------------
module bba_datapath #(
    parameter int BLOCK_BYTES = 32,
    parameter int HEAP_BYTES  = 16384
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bba_pkg::ADDR_W-1:0]      cfg_wdata,
    input  logic                            in_mode,
    input  logic [bba_pkg::SIZE_W-1:0]      in_size,
    input  logic [bba_pkg::ALIGN_W-1:0]     in_align,
    input  logic [bba_pkg::ADDR_W-1:0]      in_faddr,
    input  bba_pkg::bba_cmd_t               cmd,
    output bba_pkg::bba_sts_t               sts,
    output logic [bba_pkg::ADDR_W-1:0]      res_addr,
    output logic [bba_pkg::STATUS_W-1:0]    res_status
);

    localparam int BLK_CNT = HEAP_BYTES / BLOCK_BYTES;
    localparam int LOG2B   = $clog2(BLOCK_BYTES);
    localparam int BLK_W   = $clog2(BLK_CNT);
    localparam int CNT_W   = $clog2(BLK_CNT + 1);
    localparam int ROWS    = BLK_CNT / bba_pkg::ROW_BITS;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int NEED_W  = bba_pkg::SIZE_W + 1;
    localparam int CMP_W   = ((CNT_W > NEED_W) ? CNT_W : NEED_W) + 1;

    localparam logic [CMP_W-1:0]           BLK_CNT_C = CMP_W'(BLK_CNT);
    localparam logic [bba_pkg::ADDR_W-1:0] HEAP_C    = bba_pkg::ADDR_W'(HEAP_BYTES);
    localparam logic [NEED_W-1:0]          RND_C     = NEED_W'(BLOCK_BYTES - 1);
    localparam logic [ROW_W-1:0]           LAST_ROW  = ROW_W'(ROWS - 1);

    // configuration and request
    logic [bba_pkg::ADDR_W-1:0]  base_reg;
    logic                        mode_reg;
    logic [bba_pkg::SIZE_W-1:0]  size_reg;
    logic [bba_pkg::ALIGN_W-1:0] align_reg;
    logic [bba_pkg::ADDR_W-1:0]  faddr_reg;
    logic [CNT_W-1:0]            need_reg;

    // scan
    logic [ROW_W-1:0] iss_row_reg;
    logic             iss_done_reg;
    logic             prc_vld_reg;
    logic [ROW_W-1:0] prc_row_reg;
    logic             run_act_reg;
    logic [BLK_W-1:0] run_start_reg;
    logic [CNT_W-1:0] run_len_reg;

    // range update
    logic [BLK_W-1:0] rng_first_reg;
    logic [CNT_W-1:0] rng_end_reg;
    logic [ROW_W-1:0] mk_row_reg;
    logic [ROW_W-1:0] last_row_reg;

    logic [ROWS-1:0]  row_vld_reg;
    logic             vld_rd_reg;

    logic [bba_pkg::STATUS_W-1:0] st_reg;
    logic [bba_pkg::ADDR_W-1:0]   res_addr_reg;
    logic [bba_pkg::STATUS_W-1:0] res_status_reg;

    // decode
    logic [NEED_W-1:0]          need_full;
    logic [CMP_W-1:0]           need_cmp;
    logic [CNT_W-1:0]           need_c;
    logic [bba_pkg::ADDR_W-1:0] offset;
    logic [BLK_W-1:0]           free_first;
    logic [CMP_W-1:0]           avail;

    // ram
    logic                         ram_re;
    logic [ROW_W-1:0]             ram_raddr;
    logic [bba_pkg::ROW_BITS-1:0] ram_rdata;
    logic [bba_pkg::ROW_BITS-1:0] row_rd;
    logic [bba_pkg::ROW_BITS-1:0] row_wr;

    // scan step
    logic [15:0]      mask16;
    logic [16:0]      mask17;
    logic             scan_act;
    logic [BLK_W-1:0] scan_start;
    logic [CNT_W-1:0] scan_len;
    logic             hit;
    logic [BLK_W-1:0] hit_start;

    // range select
    logic [BLK_W-1:0] first_c;
    logic [CNT_W-1:0] end_c;
    logic [CNT_W-1:0] end_m1;

    assign need_full = (NEED_W'(size_reg) + RND_C) >> LOG2B;
    assign need_cmp  = CMP_W'(need_full);
    assign need_c    = CNT_W'(need_full);
    assign offset    = faddr_reg - base_reg;
    assign free_first = offset[LOG2B +: BLK_W];
    assign avail     = BLK_CNT_C - CMP_W'(free_first);

    assign sts.is_alloc     = (mode_reg == bba_pkg::MODE_ALLOC);
    assign sts.alloc_bad    = (need_full == '0) || (need_cmp > BLK_CNT_C);
    assign sts.free_outside = (offset >= HEAP_C) || (need_cmp > avail);
    assign sts.free_empty   = (need_full == '0);

    assign ram_re    = (cmd.scan && !iss_done_reg) || cmd.mark_rd;
    assign ram_raddr = cmd.mark_rd ? mk_row_reg : iss_row_reg;
    assign row_rd    = vld_rd_reg ? ram_rdata : '0;

    bba_ram #(
        .WIDTH (bba_pkg::ROW_BITS),
        .DEPTH (ROWS)
    ) u_map (
        .clk   (clk),
        .we    (cmd.mark_wr),
        .waddr (mk_row_reg),
        .wdata (row_wr),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mask17 = (17'd1 << align_reg) - 17'd1;
    assign mask16 = mask17[15:0];

    // one map row per cycle, eight blocks in order
    always_comb
    begin
        logic [BLK_W-1:0]           idx;
        logic [bba_pkg::ADDR_W-1:0] boff;
        logic [15:0]                baddr;
        scan_act   = run_act_reg;
        scan_start = run_start_reg;
        scan_len   = run_len_reg;
        hit        = 1'b0;
        hit_start  = run_start_reg;
        for (int k = 0; k < bba_pkg::ROW_BITS; k++)
        begin
            idx   = {prc_row_reg, bba_pkg::ROW_SH'(k)};
            boff  = bba_pkg::ADDR_W'({idx, {LOG2B{1'b0}}});
            baddr = base_reg[15:0] + boff[15:0];
            if (!hit)
            begin
                if (!row_rd[k])
                begin
                    if (scan_act)
                    begin
                        scan_len = scan_len + CNT_W'(1);
                    end
                    else if ((baddr & mask16) == 16'd0)
                    begin
                        scan_act   = 1'b1;
                        scan_start = idx;
                        scan_len   = CNT_W'(1);
                    end
                end
                else
                begin
                    scan_act = 1'b0;
                    scan_len = '0;
                end
                if (scan_act && (scan_len == need_reg))
                begin
                    hit       = 1'b1;
                    hit_start = scan_start;
                end
            end
        end
    end

    assign sts.scan_hit = prc_vld_reg && hit;
    assign sts.scan_end = prc_vld_reg && !hit && (prc_row_reg == LAST_ROW);

    assign first_c = cmd.rng_scan ? hit_start : free_first;
    assign end_c   = CNT_W'(first_c) + (cmd.rng_scan ? need_reg : need_c);
    assign end_m1  = end_c - CNT_W'(1);

    assign sts.mark_last = (mk_row_reg == last_row_reg);

    always_comb
    begin
        logic [BLK_W-1:0] idx;
        for (int k = 0; k < bba_pkg::ROW_BITS; k++)
        begin
            idx = {mk_row_reg, bba_pkg::ROW_SH'(k)};
            if ((idx >= rng_first_reg) && (CNT_W'(idx) < rng_end_reg))
            begin
                row_wr[k] = (mode_reg == bba_pkg::MODE_ALLOC);
            end
            else
            begin
                row_wr[k] = row_rd[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            row_vld_reg  <= '0;
            prc_vld_reg  <= 1'b0;
            iss_done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (cmd.mark_wr)
            begin
                row_vld_reg[mk_row_reg] <= 1'b1;
            end
            if (cmd.scan_init)
            begin
                prc_vld_reg  <= 1'b0;
                iss_done_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                prc_vld_reg <= !iss_done_reg;
                if (!iss_done_reg && (iss_row_reg == LAST_ROW))
                begin
                    iss_done_reg <= 1'b1;
                end
            end
            else
            begin
                prc_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= in_mode;
            size_reg  <= in_size;
            align_reg <= in_align;
            faddr_reg <= in_faddr;
        end
        if (ram_re)
        begin
            vld_rd_reg <= row_vld_reg[ram_raddr];
        end
        if (cmd.scan_init)
        begin
            need_reg    <= need_c;
            iss_row_reg <= '0;
            run_act_reg <= 1'b0;
            run_len_reg <= '0;
        end
        else if (cmd.scan)
        begin
            if (!iss_done_reg)
            begin
                iss_row_reg <= iss_row_reg + ROW_W'(1);
            end
            prc_row_reg <= iss_row_reg;
            if (prc_vld_reg)
            begin
                run_act_reg   <= scan_act;
                run_start_reg <= scan_start;
                run_len_reg   <= scan_len;
            end
        end
        if (cmd.rng_scan || cmd.rng_free)
        begin
            rng_first_reg <= first_c;
            rng_end_reg   <= end_c;
            mk_row_reg    <= first_c[BLK_W-1 -: ROW_W];
            last_row_reg  <= end_m1[bba_pkg::ROW_SH +: ROW_W];
        end
        else if (cmd.mark_wr)
        begin
            mk_row_reg <= mk_row_reg + ROW_W'(1);
        end
        if (cmd.st_we)
        begin
            st_reg <= cmd.st_val;
        end
        if (cmd.out_load)
        begin
            res_status_reg <= st_reg;
            if ((st_reg == bba_pkg::ST_OK) && (mode_reg == bba_pkg::MODE_ALLOC))
            begin
                res_addr_reg <= base_reg
                    + bba_pkg::ADDR_W'({rng_first_reg, {LOG2B{1'b0}}});
            end
            else
            begin
                res_addr_reg <= '0;
            end
        end
    end

    assign res_addr   = res_addr_reg;
    assign res_status = res_status_reg;

endmodule

/* rtl/core/bba_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: decode, map scan, row updates and result handoff.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bba_pkg::bba_sts_t sts,
    output bba_pkg::bba_cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_MARK_RD = 3'd3;
    localparam logic [2:0] S_MARK_WR = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_vld_reg;
    logic       out_vld_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.is_alloc && sts.alloc_bad)
                begin
                    cmd.st_we  = 1'b1;
                    cmd.st_val = bba_pkg::ST_NOSPACE;
                    state_next = S_FINISH;
                end
                else if (sts.is_alloc)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else if (sts.free_outside)
                begin
                    cmd.st_we  = 1'b1;
                    cmd.st_val = bba_pkg::ST_OUTSIDE;
                    state_next = S_FINISH;
                end
                else if (sts.free_empty)
                begin
                    cmd.st_we  = 1'b1;
                    cmd.st_val = bba_pkg::ST_OK;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rng_free = 1'b1;
                    cmd.st_we    = 1'b1;
                    cmd.st_val   = bba_pkg::ST_OK;
                    state_next   = S_MARK_RD;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                priority if (sts.scan_hit)
                begin
                    cmd.rng_scan = 1'b1;
                    cmd.st_we    = 1'b1;
                    cmd.st_val   = bba_pkg::ST_OK;
                    state_next   = S_MARK_RD;
                end
                else if (sts.scan_end)
                begin
                    cmd.st_we  = 1'b1;
                    cmd.st_val = bba_pkg::ST_NOSPACE;
                    state_next = S_FINISH;
                end
            end
            S_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                state_next  = sts.mark_last ? S_FINISH : S_MARK_RD;
            end
            S_FINISH:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        priority if (cmd.out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign out_valid = out_vld_reg;

endmodule

/* rtl/core/bitmap_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator over a bitmap of fixed-size heap blocks.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*    : heap_base write, taken any cycle (cfg_ready is tied high);
//              write only while no request is in flight.
//   s_axis_* : one request per beat. tuser = mode (0 allocate, 1 free).
//   m_axis_* : one result per request, tdata = address, tuser = status.
// Sequence:
//   A decode state follows the accepting edge. An allocate then scans the map
//   one 8-block row per cycle, ending at the first fit. A granted allocate or
//   a free then rewrites each touched row (read, then write); requests
//   rejected at decode, empty frees and allocates with no fit skip the
//   rewrite, and only allocates scan. The output register then loads once
//   it is free, and the next beat is taken the cycle after that load. One
//   request is in flight at a time.
// Reset: all blocks free (per-row valid bits), heap_base = 0, no result.
// Stall: a held result keeps m_axis_* stable; a finished request waits in
//   its last state until the output register frees up.
// BLOCK_BYTES and HEAP_BYTES are powers of two with at least 16 blocks.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int BLOCK_BYTES = 32,
    parameter int HEAP_BYTES  = 16384
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bba_pkg::ADDR_W-1:0]         cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [14:0] size_bytes, [18:15] align_log2, [50:19] free_address, rest zero
    input  logic [bba_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] address
    output logic [bba_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic [bba_pkg::STATUS_W-1:0]       m_axis_tuser
);

    bba_pkg::bba_cmd_t cmd;
    bba_pkg::bba_sts_t sts;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bba_datapath #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .HEAP_BYTES  (HEAP_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_wdata  (cfg_data),
        .in_mode    (s_axis_tuser[0]),
        .in_size    (s_axis_tdata[14:0]),
        .in_align   (s_axis_tdata[18:15]),
        .in_faddr   (s_axis_tdata[50:19]),
        .cmd        (cmd),
        .sts        (sts),
        .res_addr   (m_axis_tdata),
        .res_status (m_axis_tuser)
    );

`ifndef SYNTH
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.mark_rd, cmd.mark_wr, cmd.out_load}))
        else $error("more than one datapath action in a cycle");

    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_wr |-> $past(cmd.mark_rd))
        else $error("map row write without preceding read");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while one is in flight");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == bba_pkg::ST_OUTSIDE)) |-> (m_axis_tdata == '0))
        else $error("nonzero address on rejected free");
`endif

endmodule
